// File: rtl/core/cbb_pkg.sv
// Shared constants, types and state encodings for the contour bounding-box block.
package cbb_pkg;

   localparam int PT_W       = 12;
   localparam int CEN_W      = 13;
   localparam int TOT_W      = 16;
   localparam int RATIO_W    = 12;
   localparam int SHIFT_W    = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam int COORD_BITS_DEF = 12;
   localparam int COUNT_BITS_DEF = 16;

   localparam int MUL_W   = 24;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int ACC_W   = 3 * MUL_W;
   localparam int SQ_FRAC = 16;

   localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(599);
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(3);

   localparam logic [CSR_IDX_W-1:0] CSR_RATIO = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TRIM  = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_PREP,
      ST_TEST,
      ST_EMIT
   } top_state_type;

   typedef enum logic [3:0] {
      BS_IDLE,
      BS_SQ_CNT,
      BS_SQ_K,
      BS_SQ_DX,
      BS_SQ_DY,
      BS_SUM_D2,
      BS_MUL_LO,
      BS_MUL_HI,
      BS_ADD_HI,
      BS_CMP
   } bar_step_type;

   typedef struct packed {
      logic start;
   } bar_ctl_type;

   typedef struct packed {
      logic done;
      logic pass;
   } bar_stat_type;

endpackage

// File: rtl/core/cbb_bar_unit.sv
// Bar-validity test on one shared multiplier stepped by a small sequencer.
module cbb_bar_unit
   import cbb_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bar_ctl_type           ctl,
   input  logic [COUNT_BITS-1:0] count,
   input  logic [COORD_BITS-1:0] dx,
   input  logic [COORD_BITS-1:0] dy,
   input  logic [RATIO_W-1:0]    ratio,
   output bar_stat_type          stat
);

   localparam int LHS_W = 2 * COUNT_BITS;
   localparam int D2_W  = 2 * COORD_BITS + 1;

   bar_step_type state_ff, state_in;

   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [LHS_W-1:0]  lhs_ff;
   logic [MUL_W-1:0]  k2_ff;
   logic [D2_W-1:0]   d2_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic              pass_ff;
   logic [PROD_W-1:0] d2_pad;
   logic [ACC_W-1:0]  lhs_scaled;

   assign d2_pad     = PROD_W'(d2_ff);
   assign lhs_scaled = ACC_W'(lhs_ff) << SQ_FRAC;
   assign prod_in    = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      mul_a     = '0;
      mul_b     = '0;
      stat.done = 1'b0;
      stat.pass = pass_ff;
      case (state_ff)
         BS_IDLE: begin
            if (ctl.start) begin
               state_in = BS_SQ_CNT;
            end
         end
         BS_SQ_CNT: begin
            mul_a    = MUL_W'(count);
            mul_b    = MUL_W'(count);
            state_in = BS_SQ_K;
         end
         BS_SQ_K: begin
            mul_a    = MUL_W'(ratio);
            mul_b    = MUL_W'(ratio);
            state_in = BS_SQ_DX;
         end
         BS_SQ_DX: begin
            mul_a    = MUL_W'(dx);
            mul_b    = MUL_W'(dx);
            state_in = BS_SQ_DY;
         end
         BS_SQ_DY: begin
            mul_a    = MUL_W'(dy);
            mul_b    = MUL_W'(dy);
            state_in = BS_SUM_D2;
         end
         BS_SUM_D2: begin
            state_in = BS_MUL_LO;
         end
         BS_MUL_LO: begin
            mul_a    = k2_ff;
            mul_b    = d2_pad[MUL_W-1:0];
            state_in = BS_MUL_HI;
         end
         BS_MUL_HI: begin
            mul_a    = k2_ff;
            mul_b    = d2_pad[PROD_W-1:MUL_W];
            state_in = BS_ADD_HI;
         end
         BS_ADD_HI: begin
            state_in = BS_CMP;
         end
         BS_CMP: begin
            stat.done = 1'b1;
            state_in  = BS_IDLE;
         end
         default: begin
            state_in = BS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (state_ff)
         BS_SQ_K:   lhs_ff  <= prod_ff[LHS_W-1:0];
         BS_SQ_DX:  k2_ff   <= prod_ff[MUL_W-1:0];
         BS_SQ_DY:  d2_ff   <= D2_W'(prod_ff);
         BS_SUM_D2: d2_ff   <= d2_ff + D2_W'(prod_ff);
         BS_MUL_HI: acc_ff  <= ACC_W'(prod_ff);
         BS_ADD_HI: acc_ff  <= acc_ff + (ACC_W'(prod_ff) << MUL_W);
         BS_CMP:    pass_ff <= (lhs_scaled <= acc_ff);
         default: begin
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> state_ff == BS_IDLE)
      else $error("bar test started while busy");

   a_cmp_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == BS_CMP |=> state_ff == BS_IDLE)
      else $error("bar test did not return to idle after compare");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BS_IDLE && !ctl.start) |=> state_ff == BS_IDLE)
      else $error("bar test left idle without start");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BS_IDLE && ctl.start) |=> state_ff == BS_SQ_CNT)
      else $error("bar test did not begin after start");
`endif

endmodule

// File: rtl/core/contour_bbox_bar_test.sv
// Top level of the contour bounding-box accumulator with bar-validity test.
//
//   Channel  Direction  Handshake              Contents
//   req      in         req_valid/req_stall    one contour point and its last flag
//   rsp      out        rsp_valid/rsp_stall    box, centre, axis, trim, count, validity
//   csr      in         csr_wr_en              ratio threshold and trim shift writes
//
// A point that is not the last one is taken without a stall, so such points stream back to back.
// A last point holds the input while the block forms the spans, runs the validity test in
// nine sequencer steps around the shared 24x24 multiplier, and then loads the result.
// The load waits while an earlier result is still stalled on the output.
// Reset is synchronous and returns the running box, count and registers to defaults.
module contour_bbox_bar_test
   import cbb_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PT_W-1:0]       req_point_x,
   input  logic [PT_W-1:0]       req_point_y,
   input  logic                  req_last_point,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PT_W-1:0]       rsp_box_min_x,
   output logic [PT_W-1:0]       rsp_box_max_x,
   output logic [PT_W-1:0]       rsp_box_min_y,
   output logic [PT_W-1:0]       rsp_box_max_y,
   output logic [CEN_W-1:0]      rsp_centre_x_doubled,
   output logic [CEN_W-1:0]      rsp_centre_y_doubled,
   output logic                  rsp_long_axis_horizontal,
   output logic [PT_W-1:0]       rsp_trim_low,
   output logic [PT_W-1:0]       rsp_trim_high,
   output logic [TOT_W-1:0]      rsp_total_points,
   output logic                  rsp_bar_valid,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int EXT_W = COORD_BITS + CEN_W + TOT_W + COUNT_BITS;

   top_state_type state_ff, state_in;

   logic [RATIO_W-1:0]    ratio_ff;
   logic [SHIFT_W-1:0]    shift_ff;
   logic [COORD_BITS-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COORD_BITS-1:0] dx_ff, dy_ff, cut_ff;
   logic                  horiz_ff;
   logic                  rsp_valid_ff;

   logic                  req_take, out_free, load_out;
   logic [EXT_W-1:0]      x_ext, y_ext;
   logic [COORD_BITS-1:0] x_c, y_c;
   logic [COORD_BITS-1:0] span, sel_min, sel_max, hi_diff;
   logic [COORD_BITS:0]   lo_sum, cx_sum, cy_sum;
   logic [EXT_W-1:0]      lo_ext, hi_ext, cx_ext, cy_ext, cnt_ext;
   logic [EXT_W-1:0]      mnx_ext, mxx_ext, mny_ext, mxy_ext;

   bar_ctl_type  bar_ctl;
   bar_stat_type bar_stat;

   assign x_ext    = EXT_W'(req_point_x);
   assign y_ext    = EXT_W'(req_point_y);
   assign x_c      = x_ext[COORD_BITS-1:0];
   assign y_c      = y_ext[COORD_BITS-1:0];
   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   assign span    = (dx_ff > dy_ff) ? dx_ff : dy_ff;
   assign sel_min = horiz_ff ? min_x_ff : min_y_ff;
   assign sel_max = horiz_ff ? max_x_ff : max_y_ff;
   assign lo_sum  = (COORD_BITS+1)'(sel_min) + (COORD_BITS+1)'(cut_ff);
   assign hi_diff = sel_max - cut_ff;
   assign cx_sum  = (COORD_BITS+1)'(min_x_ff) + (COORD_BITS+1)'(max_x_ff);
   assign cy_sum  = (COORD_BITS+1)'(min_y_ff) + (COORD_BITS+1)'(max_y_ff);
   assign lo_ext  = EXT_W'(lo_sum);
   assign hi_ext  = EXT_W'(hi_diff);
   assign cx_ext  = EXT_W'(cx_sum);
   assign cy_ext  = EXT_W'(cy_sum);
   assign cnt_ext = EXT_W'(count_ff);
   assign mnx_ext = EXT_W'(min_x_ff);
   assign mxx_ext = EXT_W'(max_x_ff);
   assign mny_ext = EXT_W'(min_y_ff);
   assign mxy_ext = EXT_W'(max_y_ff);

   cbb_bar_unit #(
      .COORD_BITS (COORD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_bar (
      .clock (clock),
      .reset (reset),
      .ctl   (bar_ctl),
      .count (count_ff),
      .dx    (dx_ff),
      .dy    (dy_ff),
      .ratio (ratio_ff),
      .stat  (bar_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_stall     = 1'b1;
      bar_ctl.start = 1'b0;
      load_out      = 1'b0;
      case (state_ff)
         ST_ACCUM: begin
            req_stall = 1'b0;
            if (req_valid && req_last_point) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            bar_ctl.start = 1'b1;
            state_in      = ST_TEST;
         end
         ST_TEST: begin
            if (bar_stat.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= RATIO_RESET;
         shift_ff <= SHIFT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RATIO: ratio_ff <= csr_wdata[RATIO_W-1:0];
            CSR_TRIM:  shift_ff <= csr_wdata[SHIFT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || load_out) begin
         min_x_ff <= '1;
         max_x_ff <= '0;
         min_y_ff <= '1;
         max_y_ff <= '0;
         count_ff <= '0;
      end else if (req_take) begin
         if (x_c < min_x_ff) min_x_ff <= x_c;
         if (x_c > max_x_ff) max_x_ff <= x_c;
         if (y_c < min_y_ff) min_y_ff <= y_c;
         if (y_c > max_y_ff) max_y_ff <= y_c;
         if (count_ff != '1) count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_PREP) begin
         dx_ff <= max_x_ff - min_x_ff;
         dy_ff <= max_y_ff - min_y_ff;
      end
      if (state_ff == ST_TEST) begin
         horiz_ff <= dx_ff > dy_ff;
         cut_ff   <= span >> shift_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_box_min_x            <= mnx_ext[PT_W-1:0];
         rsp_box_max_x            <= mxx_ext[PT_W-1:0];
         rsp_box_min_y            <= mny_ext[PT_W-1:0];
         rsp_box_max_y            <= mxy_ext[PT_W-1:0];
         rsp_centre_x_doubled     <= cx_ext[CEN_W-1:0];
         rsp_centre_y_doubled     <= cy_ext[CEN_W-1:0];
         rsp_long_axis_horizontal <= horiz_ff;
         rsp_trim_low             <= lo_ext[PT_W-1:0];
         rsp_trim_high            <= hi_ext[PT_W-1:0];
         rsp_total_points         <= cnt_ext[TOT_W-1:0];
         rsp_bar_valid            <= bar_stat.pass;
      end
   end

`ifndef ASSERT_OFF
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free) |=> (rsp_valid_ff && count_ff == '0))
      else $error("result load did not raise valid and clear the count");

   a_test_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEST && bar_stat.done) |=> state_ff == ST_EMIT)
      else $error("finished bar test did not move to result load");

   a_done_in_test: assert property (@(posedge clock) disable iff (reset)
      bar_stat.done |-> state_ff == ST_TEST)
      else $error("bar test finished outside the test phase");

   a_prep_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PREP |=> state_ff == ST_TEST)
      else $error("span preparation did not lead to the test phase");
`endif

endmodule

// File: tb/tb_contour_bbox_bar_test.sv
// Self-checking testbench for the contour bounding-box accumulator with bar-validity test.
`timescale 1ns / 100ps

module tb_contour_bbox_bar_test;
   import cbb_pkg::*;

   localparam int RUN_LIMIT = 1_000_000;
   localparam int PHASES = 6;
   localparam int PHASE_POINTS = 205;
   localparam int SETTLE_CYCLES = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = CSR_IDX_W'(3);

   typedef struct packed {
      logic [PT_W-1:0]  min_x;
      logic [PT_W-1:0]  max_x;
      logic [PT_W-1:0]  min_y;
      logic [PT_W-1:0]  max_y;
      logic [CEN_W-1:0] cen_x;
      logic [CEN_W-1:0] cen_y;
      logic             horiz;
      logic [PT_W-1:0]  trim_lo;
      logic [PT_W-1:0]  trim_hi;
      logic [TOT_W-1:0] total;
      logic             bar_ok;
   } box_report_type;

   typedef struct packed {
      logic [PT_W-1:0] x;
      logic [PT_W-1:0] y;
      logic            last;
      logic            typed;
      box_report_type  want;
   } point_row_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PT_W-1:0]       req_point_x = '0;
   logic [PT_W-1:0]       req_point_y = '0;
   logic                  req_last_point = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PT_W-1:0]       rsp_box_min_x;
   logic [PT_W-1:0]       rsp_box_max_x;
   logic [PT_W-1:0]       rsp_box_min_y;
   logic [PT_W-1:0]       rsp_box_max_y;
   logic [CEN_W-1:0]      rsp_centre_x_doubled;
   logic [CEN_W-1:0]      rsp_centre_y_doubled;
   logic                  rsp_long_axis_horizontal;
   logic [PT_W-1:0]       rsp_trim_low;
   logic [PT_W-1:0]       rsp_trim_high;
   logic [TOT_W-1:0]      rsp_total_points;
   logic                  rsp_bar_valid;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [RATIO_W-1:0] ratio_cfg = RATIO_RESET;
   logic [SHIFT_W-1:0] shift_cfg = SHIFT_RESET;
   logic [PT_W-1:0]    acc_min_x = '1;
   logic [PT_W-1:0]    acc_max_x = '0;
   logic [PT_W-1:0]    acc_min_y = '1;
   logic [PT_W-1:0]    acc_max_y = '0;
   logic [TOT_W-1:0]   acc_count = '0;

   box_report_type pending_boxes[$];
   point_row_type  directed[$];

   int unsigned ratio_plan [PHASES] = '{4095, 0, 1, 300, 599, 2048};
   int unsigned shift_plan [PHASES] = '{0, 7, 1, 5, 3, 2};

   int points_sent = 0;
   int boxes_checked = 0;
   int errors = 0;
   int cycle_count = 0;
   int send_pct = 0;
   int recv_pct = 0;
   int send_quiet = 0;
   int recv_quiet = 0;

   contour_bbox_bar_test u_dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_point_x              (req_point_x),
      .req_point_y              (req_point_y),
      .req_last_point           (req_last_point),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_box_min_x            (rsp_box_min_x),
      .rsp_box_max_x            (rsp_box_max_x),
      .rsp_box_min_y            (rsp_box_min_y),
      .rsp_box_max_y            (rsp_box_max_y),
      .rsp_centre_x_doubled     (rsp_centre_x_doubled),
      .rsp_centre_y_doubled     (rsp_centre_y_doubled),
      .rsp_long_axis_horizontal (rsp_long_axis_horizontal),
      .rsp_trim_low             (rsp_trim_low),
      .rsp_trim_high            (rsp_trim_high),
      .rsp_total_points         (rsp_total_points),
      .rsp_bar_valid            (rsp_bar_valid),
      .csr_wr_en                (csr_wr_en),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic bit fold_point(input logic [PT_W-1:0] x, input logic [PT_W-1:0] y,
                                     input logic last, output box_report_type rep);
      int unsigned dx;
      int unsigned dy;
      int unsigned cut;
      longint unsigned scaled;
      longint unsigned k_sq;
      longint unsigned diag_sq;
      rep = '0;
      if (x < acc_min_x) acc_min_x = x;
      if (x > acc_max_x) acc_max_x = x;
      if (y < acc_min_y) acc_min_y = y;
      if (y > acc_max_y) acc_max_y = y;
      if (acc_count != '1) acc_count = acc_count + 1'b1;
      if (!last) return 1'b0;
      dx = acc_max_x - acc_min_x;
      dy = acc_max_y - acc_min_y;
      rep.min_x = acc_min_x;
      rep.max_x = acc_max_x;
      rep.min_y = acc_min_y;
      rep.max_y = acc_max_y;
      rep.cen_x = CEN_W'(acc_min_x) + CEN_W'(acc_max_x);
      rep.cen_y = CEN_W'(acc_min_y) + CEN_W'(acc_max_y);
      rep.horiz = dx > dy;
      if (rep.horiz) begin
         cut = dx >> shift_cfg;
         rep.trim_lo = PT_W'(acc_min_x + cut);
         rep.trim_hi = PT_W'(acc_max_x - cut);
      end else begin
         cut = dy >> shift_cfg;
         rep.trim_lo = PT_W'(acc_min_y + cut);
         rep.trim_hi = PT_W'(acc_max_y - cut);
      end
      rep.total = acc_count;
      scaled = 64'(acc_count) << 8;
      k_sq = 64'(ratio_cfg) * 64'(ratio_cfg);
      diag_sq = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
      rep.bar_ok = (scaled < (64'd1 << 32)) && (scaled * scaled <= k_sq * diag_sq);
      acc_min_x = '1;
      acc_max_x = '0;
      acc_min_y = '1;
      acc_max_y = '0;
      acc_count = '0;
      return 1'b1;
   endfunction

   function automatic box_report_type report(input int unsigned mnx, input int unsigned mxx,
                                             input int unsigned mny, input int unsigned mxy,
                                             input int unsigned cx, input int unsigned cy,
                                             input bit horiz, input int unsigned lo,
                                             input int unsigned hi, input int unsigned total,
                                             input bit bar_ok);
      box_report_type r;
      r.min_x = PT_W'(mnx);
      r.max_x = PT_W'(mxx);
      r.min_y = PT_W'(mny);
      r.max_y = PT_W'(mxy);
      r.cen_x = CEN_W'(cx);
      r.cen_y = CEN_W'(cy);
      r.horiz = horiz;
      r.trim_lo = PT_W'(lo);
      r.trim_hi = PT_W'(hi);
      r.total = TOT_W'(total);
      r.bar_ok = bar_ok;
      return r;
   endfunction

   function automatic point_row_type row(input int unsigned x, input int unsigned y,
                                         input bit last, input bit typed,
                                         input box_report_type want);
      point_row_type r;
      r.x = PT_W'(x);
      r.y = PT_W'(y);
      r.last = last;
      r.typed = typed;
      r.want = want;
      return r;
   endfunction

   function automatic void add_row(input point_row_type r);
      directed.insert(directed.size(), r);
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   task automatic send_point(input logic [PT_W-1:0] x, input logic [PT_W-1:0] y,
                             input logic last, input bit use_given,
                             input box_report_type given);
      logic stalled;
      box_report_type predicted;
      if (send_quiet > 0) send_quiet--;
      else if ($urandom_range(0, 99) < 2) send_quiet = $urandom_range(10, 40);
      if (send_quiet == 0) begin
         while ($urandom_range(0, 99) < send_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_last_point <= last;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      points_sent++;
      if (fold_point(x, y, last, predicted))
         pending_boxes.insert(pending_boxes.size(), use_given ? given : predicted);
   endtask

   task automatic send_contour(input int len, input int unsigned w);
      int unsigned bx;
      int unsigned by;
      bx = $urandom_range(0, 4095 - w);
      by = $urandom_range(0, 4095 - w);
      for (int i = 0; i < len; i++) begin
         send_point(PT_W'(bx + $urandom_range(0, w)), PT_W'(by + $urandom_range(0, w)),
                    i == len - 1, 1'b0, '0);
      end
   endtask

   task automatic drain(input int extra);
      req_valid <= 1'b0;
      while (pending_boxes.size() > 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic program_regs(input logic [RATIO_W-1:0] ratio, input logic [SHIFT_W-1:0] shift,
                               input bit poke_spare);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_RATIO;
      csr_wdata <= CSR_DATA_W'(ratio);
      @(posedge clock);
      ratio_cfg = ratio;
      csr_index <= CSR_TRIM;
      csr_wdata <= CSR_DATA_W'(shift);
      @(posedge clock);
      shift_cfg = shift;
      if (poke_spare) begin
         csr_index <= CSR_SPARE_A;
         csr_wdata <= '1;
         @(posedge clock);
         csr_index <= CSR_SPARE_B;
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (recv_quiet > 0) recv_quiet--;
         else if ($urandom_range(0, 99) < 2) recv_quiet = $urandom_range(10, 40);
         rsp_stall <= (recv_quiet == 0) && ($urandom_range(0, 99) < recv_pct);
      end
   end

   always @(negedge clock) begin
      box_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_boxes.size() == 0) begin
            $display("%0t ns: result arrived with none expected, expected nothing, got box %0d..%0d",
                     $time, rsp_box_min_x, rsp_box_max_x);
            errors++;
         end else begin
            want = pending_boxes.pop_front();
            boxes_checked++;
            check_field("box_min_x", want.min_x, rsp_box_min_x);
            check_field("box_max_x", want.max_x, rsp_box_max_x);
            check_field("box_min_y", want.min_y, rsp_box_min_y);
            check_field("box_max_y", want.max_y, rsp_box_max_y);
            check_field("centre_x_doubled", want.cen_x, rsp_centre_x_doubled);
            check_field("centre_y_doubled", want.cen_y, rsp_centre_y_doubled);
            check_field("long_axis_horizontal", want.horiz, rsp_long_axis_horizontal);
            check_field("trim_low", want.trim_lo, rsp_trim_low);
            check_field("trim_high", want.trim_hi, rsp_trim_high);
            check_field("total_points", want.total, rsp_total_points);
            check_field("bar_valid", want.bar_ok, rsp_bar_valid);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("%0t ns: run limit of %0d cycles reached with %0d results outstanding",
                  $time, RUN_LIMIT, pending_boxes.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int len;
      int start;
      int unsigned w;
      int pick;

      // Extremes of the box with their results typed in; the rest come from the predictor.
      add_row(row(0, 0, 1, 1, report(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0)));
      add_row(row(4095, 4095, 1, 1,
                  report(4095, 4095, 4095, 4095, 8190, 8190, 0, 4095, 4095, 1, 0)));
      add_row(row(0, 0, 0, 0, '0));
      add_row(row(4095, 4095, 1, 1,
                  report(0, 4095, 0, 4095, 4095, 4095, 0, 511, 3584, 2, 1)));
      add_row(row(0, 100, 0, 0, '0));
      add_row(row(4095, 100, 1, 1,
                  report(0, 4095, 100, 100, 4095, 200, 1, 511, 3584, 2, 1)));
      add_row(row(7, 0, 0, 0, '0));
      add_row(row(7, 4095, 1, 1,
                  report(7, 7, 0, 4095, 14, 4095, 0, 511, 3584, 2, 1)));
      add_row(row(1, 1, 0, 0, '0));
      add_row(row(2, 0, 0, 0, '0));
      add_row(row(0, 2, 0, 0, '0));
      add_row(row(2, 2, 0, 0, '0));
      add_row(row(1, 0, 0, 0, '0));
      add_row(row(0, 1, 0, 0, '0));
      add_row(row(2, 1, 0, 0, '0));
      add_row(row(1, 2, 0, 0, '0));
      add_row(row(0, 0, 0, 0, '0));
      add_row(row(1, 1, 1, 0, '0));
      add_row(row(2730, 1365, 0, 0, '0));
      add_row(row(1365, 2730, 1, 0, '0));
      add_row(row(100, 200, 0, 0, '0));
      add_row(row(300, 250, 0, 0, '0));
      add_row(row(50, 900, 0, 0, '0));
      add_row(row(120, 400, 1, 0, '0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_pct = 35;
      recv_pct = 73;
      foreach (directed[i])
         send_point(directed[i].x, directed[i].y, directed[i].last, directed[i].typed,
                    directed[i].want);

      for (int ph = 0; ph < PHASES; ph++) begin
         drain(SETTLE_CYCLES);
         program_regs(RATIO_W'(ratio_plan[ph]), SHIFT_W'(shift_plan[ph]), ph == 3);
         case (ph / 2)
            0: begin
               send_pct = 35;
               recv_pct = 73;
            end
            1: begin
               send_pct = 73;
               recv_pct = 35;
            end
            default: begin
               send_pct = 0;
               recv_pct = 0;
            end
         endcase
         start = points_sent;
         while (points_sent - start < PHASE_POINTS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) len = $urandom_range(1, 8);
            else if (pick < 95) len = $urandom_range(9, 40);
            else len = $urandom_range(41, 150);
            case ($urandom_range(0, 3))
               0: w = 3;
               1: w = 31;
               2: w = 511;
               default: w = 4095;
            endcase
            send_contour(len, w);
         end
      end

      drain(SETTLE_CYCLES);

      $display("Checked %0d contour results from %0d points under %0d register settings,",
               boxes_checked, points_sent, PHASES + 1);
      $display("with sender and receiver idling 35/73, then 73/35, then not at all.");
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
